>>> rtl/core/xdnt_pkg.sv
// Package for the XOR-distance node table: command, response and entry types,
// status, opcode and register index codes, and the sequencer state type.
// No dependencies.
package xdnt_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_AFTER = 1'b1;

    localparam logic [15:0] STALE_AFTER_RST = 16'd130;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    localparam logic [2:0] ST_REFRESHED  = 3'd0;
    localparam logic [2:0] ST_STALE      = 3'd1;
    localparam logic [2:0] ST_FARTHER    = 3'd2;
    localparam logic [2:0] ST_NOT_STORED = 3'd3;
    localparam logic [2:0] ST_REPLY      = 3'd4;
    localparam logic [2:0] ST_NONE       = 3'd5;

    typedef struct packed {
        logic        opcode;
        logic [31:0] now_time;
        logic [63:0] node_id;
        logic [31:0] ip_addr;
        logic [15:0] port_num;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] out_id;
        logic [31:0] out_ip;
        logic [15:0] out_port;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [63:0] id;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] seen;
    } entry_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_EVAL,
        S_ADD_WR,
        S_FIND_RD,
        S_FIND_EVAL,
        S_FIND_CMP,
        S_OUT_RD,
        S_OUT_EMIT
    } state_t;

endpackage

>>> rtl/core/xor_distance_node_table_unit.sv
// XOR-distance node table: entry memory, compare datapath and sequencer.
// Depends on xdnt_pkg.
//
// Usage:
//   Command channel: cmd is taken at a rising edge with start high and busy low.
//   opcode add refreshes, fills a stale slot, displaces a farther peer or
//   stores nothing, with one response; find gives one response per fresh
//   peer picked (status reply, last on the final one) or one no-nodes response.
//   Responses: rsp is valid for exactly one cycle while rsp_strobe is high;
//   the receiver cannot stall, so no response is ever held back.
//   Config channel: cfg_index/cfg_data are written when cfg_valid is high;
//   cfg_ready is always high. Write only while busy is low.
//   Flow: one memory read port serves the scans, each entry being read and
//   then evaluated. Add scans the entries and then writes (it ends early on a
//   refresh hit). Find scans every entry, compares each fresh one against the
//   reply set, then reads and emits each picked entry as a response in turn.
//   One item is in work at a time; busy stays high until its last response.
//   Reset: the control registers return to reset values and a clearing pass
//   writes zero to every entry with busy high; config writes still work.
module xor_distance_node_table_unit #(
    parameter int TABLE_ENTRIES = 32,
    parameter int REPLY_NODES   = 8,
    parameter int ID_BYTES      = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  xdnt_pkg::cmd_t                 cmd,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [xdnt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    output logic                           rsp_strobe,
    output xdnt_pkg::rsp_t                 rsp
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SEL_W = (REPLY_NODES > 1) ? $clog2(REPLY_NODES) : 1;
    localparam int CNT_W = $clog2(REPLY_NODES + 1);
    localparam logic [63:0] ID_MASK = {64{1'b1}} >> (64 - 8 * ID_BYTES);

    xdnt_pkg::state_t state_reg, state_next;

    xdnt_pkg::cmd_t cmd_reg, cmd_next;
    logic [63:0] self_id_reg, self_id_next;
    logic [15:0] stale_reg, stale_next;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             hit_b_reg, hit_b_next;
    logic [IDX_W-1:0] b_idx_reg, b_idx_next;
    logic             hit_f_reg, hit_f_next;
    logic [IDX_W-1:0] f_idx_reg, f_idx_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SEL_W-1:0] j_reg, j_next;
    logic             far_hit_reg, far_hit_next;
    logic [SEL_W-1:0] far_idx_reg, far_idx_next;
    logic [63:0]      cand_id_reg, cand_id_next;

    logic [IDX_W-1:0] sel_idx_reg [REPLY_NODES];
    logic [63:0]      sel_id_reg  [REPLY_NODES];
    logic             sel_we;
    logic [SEL_W-1:0] sel_waddr;

    xdnt_pkg::rsp_t rsp_reg, rsp_next;
    logic           rsp_strobe_reg, rsp_strobe_next;

    xdnt_pkg::entry_t mem [TABLE_ENTRIES];
    xdnt_pkg::entry_t rdata_reg;
    xdnt_pkg::entry_t mem_wdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;

    logic [32:0] expiry;
    logic [32:0] now33;
    logic        is_bad;
    logic        is_fresh;
    logic        is_match;
    logic        is_far;
    logic [63:0] mbr_id;
    logic        mbr_dup;
    logic        mbr_far;
    logic        idx_last;
    logic        j_last;
    logic        set_full;
    logic        adv;

    assign busy       = (state_reg != xdnt_pkg::S_IDLE);
    assign cfg_ready  = 1'b1;
    assign rsp_strobe = rsp_strobe_reg;
    assign rsp        = rsp_reg;

    assign mem_raddr = (state_reg == xdnt_pkg::S_OUT_RD) ? sel_idx_reg[j_reg] : idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign expiry   = {1'b0, rdata_reg.seen} + {17'd0, stale_reg};
    assign now33    = {1'b0, cmd_reg.now_time};
    assign is_bad   = (expiry < now33);
    assign is_fresh = (expiry > now33);
    assign is_match = ((rdata_reg.ip == cmd_reg.ip_addr) && (rdata_reg.port == cmd_reg.port_num))
                      || (rdata_reg.id == cmd_reg.node_id);
    assign is_far   = ((rdata_reg.id ^ self_id_reg) > (cmd_reg.node_id ^ self_id_reg));

    assign mbr_id   = sel_id_reg[j_reg];
    assign mbr_dup  = (mbr_id == cand_id_reg);
    assign mbr_far  = ((mbr_id ^ cmd_reg.node_id) > (cand_id_reg ^ cmd_reg.node_id));

    assign idx_last = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign j_last   = ((CNT_W'(j_reg) + CNT_W'(1)) == cnt_reg);
    assign set_full = (cnt_reg == CNT_W'(REPLY_NODES));

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        self_id_next    = self_id_reg;
        stale_next      = stale_reg;
        idx_next        = idx_reg;
        hit_b_next      = hit_b_reg;
        b_idx_next      = b_idx_reg;
        hit_f_next      = hit_f_reg;
        f_idx_next      = f_idx_reg;
        cnt_next        = cnt_reg;
        j_next          = j_reg;
        far_hit_next    = far_hit_reg;
        far_idx_next    = far_idx_reg;
        cand_id_next    = cand_id_reg;
        sel_we          = 1'b0;
        sel_waddr       = '0;
        rsp_next        = rsp_reg;
        rsp_strobe_next = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = '{id: cmd_reg.node_id, ip: cmd_reg.ip_addr,
                            port: cmd_reg.port_num, seen: cmd_reg.now_time};
        adv             = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                xdnt_pkg::CFG_SELF_ID:     self_id_next = cfg_data & ID_MASK;
                xdnt_pkg::CFG_STALE_AFTER: stale_next = cfg_data[15:0];
                default:                   ;
            endcase
        end

        unique case (state_reg)
            xdnt_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                idx_next  = idx_reg + IDX_W'(1);
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = xdnt_pkg::S_IDLE;
                end
            end
            xdnt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next         = cmd;
                    cmd_next.node_id = cmd.node_id & ID_MASK;
                    idx_next         = '0;
                    hit_b_next       = 1'b0;
                    hit_f_next       = 1'b0;
                    cnt_next         = '0;
                    state_next       = (cmd.opcode == xdnt_pkg::OP_FIND) ?
                                       xdnt_pkg::S_FIND_RD : xdnt_pkg::S_ADD_RD;
                end
            end
            xdnt_pkg::S_ADD_RD:
            begin
                state_next = xdnt_pkg::S_ADD_EVAL;
            end
            xdnt_pkg::S_ADD_EVAL:
            begin
                if (is_match)
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = '{id: cmd_reg.node_id, ip: rdata_reg.ip,
                                        port: rdata_reg.port, seen: cmd_reg.now_time};
                    rsp_next        = '{status: xdnt_pkg::ST_REFRESHED, out_id: 64'd0,
                                        out_ip: 32'd0, out_port: 16'd0, last: 1'b1};
                    rsp_strobe_next = 1'b1;
                    state_next      = xdnt_pkg::S_IDLE;
                end
                else
                begin
                    if (!hit_b_reg && is_bad)
                    begin
                        hit_b_next = 1'b1;
                        b_idx_next = idx_reg;
                    end
                    if (!hit_f_reg && is_far)
                    begin
                        hit_f_next = 1'b1;
                        f_idx_next = idx_reg;
                    end
                    if (idx_last)
                    begin
                        state_next = xdnt_pkg::S_ADD_WR;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = xdnt_pkg::S_ADD_RD;
                    end
                end
            end
            xdnt_pkg::S_ADD_WR:
            begin
                mem_we          = hit_b_reg || hit_f_reg;
                mem_waddr       = hit_b_reg ? b_idx_reg : f_idx_reg;
                rsp_next        = '{status: xdnt_pkg::ST_NOT_STORED, out_id: 64'd0,
                                    out_ip: 32'd0, out_port: 16'd0, last: 1'b1};
                if (hit_b_reg)
                begin
                    rsp_next.status = xdnt_pkg::ST_STALE;
                end
                else if (hit_f_reg)
                begin
                    rsp_next.status = xdnt_pkg::ST_FARTHER;
                end
                rsp_strobe_next = 1'b1;
                state_next      = xdnt_pkg::S_IDLE;
            end
            xdnt_pkg::S_FIND_RD:
            begin
                state_next = xdnt_pkg::S_FIND_EVAL;
            end
            xdnt_pkg::S_FIND_EVAL:
            begin
                cand_id_next = rdata_reg.id;
                j_next       = '0;
                far_hit_next = 1'b0;
                if (!is_fresh)
                begin
                    adv = 1'b1;
                end
                else if (cnt_reg == '0)
                begin
                    sel_we    = 1'b1;
                    sel_waddr = '0;
                    cnt_next  = CNT_W'(1);
                    adv       = 1'b1;
                end
                else
                begin
                    state_next = xdnt_pkg::S_FIND_CMP;
                end
            end
            xdnt_pkg::S_FIND_CMP:
            begin
                if (mbr_dup)
                begin
                    adv = 1'b1;
                end
                else if (j_last)
                begin
                    if (!set_full)
                    begin
                        sel_we    = 1'b1;
                        sel_waddr = SEL_W'(cnt_reg);
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    else if (far_hit_reg || mbr_far)
                    begin
                        sel_we    = 1'b1;
                        sel_waddr = far_hit_reg ? far_idx_reg : j_reg;
                    end
                    adv = 1'b1;
                end
                else
                begin
                    if (!far_hit_reg && mbr_far)
                    begin
                        far_hit_next = 1'b1;
                        far_idx_next = j_reg;
                    end
                    j_next = j_reg + SEL_W'(1);
                end
            end
            xdnt_pkg::S_OUT_RD:
            begin
                state_next = xdnt_pkg::S_OUT_EMIT;
            end
            xdnt_pkg::S_OUT_EMIT:
            begin
                rsp_next        = '{status: xdnt_pkg::ST_REPLY, out_id: rdata_reg.id,
                                    out_ip: rdata_reg.ip, out_port: rdata_reg.port,
                                    last: j_last};
                rsp_strobe_next = 1'b1;
                if (j_last)
                begin
                    state_next = xdnt_pkg::S_IDLE;
                end
                else
                begin
                    j_next     = j_reg + SEL_W'(1);
                    state_next = xdnt_pkg::S_OUT_RD;
                end
            end
            default:
            begin
                state_next = xdnt_pkg::S_IDLE;
            end
        endcase

        // advance the find scan to the next entry or to the reply phase, or give the no-nodes response
        if (adv)
        begin
            if (!idx_last)
            begin
                idx_next   = idx_reg + IDX_W'(1);
                state_next = xdnt_pkg::S_FIND_RD;
            end
            else if (cnt_next == '0)
            begin
                rsp_next        = '{status: xdnt_pkg::ST_NONE, out_id: 64'd0,
                                    out_ip: 32'd0, out_port: 16'd0, last: 1'b1};
                rsp_strobe_next = 1'b1;
                state_next      = xdnt_pkg::S_IDLE;
            end
            else
            begin
                j_next     = '0;
                state_next = xdnt_pkg::S_OUT_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= xdnt_pkg::S_CLEAR;
            self_id_reg    <= '0;
            stale_reg      <= xdnt_pkg::STALE_AFTER_RST;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            j_reg          <= '0;
            hit_b_reg      <= 1'b0;
            hit_f_reg      <= 1'b0;
            far_hit_reg    <= 1'b0;
            rsp_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            self_id_reg    <= self_id_next;
            stale_reg      <= stale_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            j_reg          <= j_next;
            hit_b_reg      <= hit_b_next;
            hit_f_reg      <= hit_f_next;
            far_hit_reg    <= far_hit_next;
            rsp_strobe_reg <= rsp_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        b_idx_reg   <= b_idx_next;
        f_idx_reg   <= f_idx_next;
        far_idx_reg <= far_idx_next;
        cand_id_reg <= cand_id_next;
        rsp_reg     <= rsp_next;
        if (sel_we)
        begin
            sel_idx_reg[sel_waddr] <= idx_reg;
            sel_id_reg[sel_waddr]  <= rdata_reg.id;
        end
    end

    // the candidate id is still in rdata_reg during the compare pass
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_strobe && rsp.last) |-> !busy)
        else $error("final response while item still in work");

    a_mid_is_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_strobe && !rsp.last) |-> (busy && rsp.status == xdnt_pkg::ST_REPLY))
        else $error("non-final response is not a node reply");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(REPLY_NODES))
        else $error("reply set overflow");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != xdnt_pkg::S_IDLE))
        else $error("table written while idle");

endmodule
